@@ hw/rtl/bia_pkg.sv @@
package bia_pkg;

	// Bitmap geometry: one bit per identifier, 32 identifiers per word
	localparam int WORDS     = 1024;
	localparam int USE_WORDS = (WORDS < 1024) ? WORDS : 1024;
	localparam int AW        = $clog2(WORDS);
	localparam int UAW       = $clog2(USE_WORDS);
	localparam int TW        = $clog2(USE_WORDS + 1);

	localparam logic [31:0] FULL_WORD   = 32'hffff_ffff;
	localparam logic [15:0] LFSR_TAPS   = 16'hb400;
	localparam logic [16:0] IDENT_LIMIT = 17'(USE_WORDS * 32);
	localparam logic [15:0] NO_IDENT    = 16'hffff;

	// Register reset values
	localparam logic [15:0] LIMIT_RESET = 16'd16384;
	localparam logic [15:0] SEED_RESET  = 16'd1;

	// Configuration address: byte address 4*i, selected by paddr[2]
	localparam int PADDR_W = 3;

	typedef enum logic {
		REG_COUNT_LIMIT,
		REG_PROBE_SEED
	} reg_sel_t;

	typedef enum logic [1:0] {
		ACT_ALLOC,
		ACT_CHECK,
		ACT_REQUEST,
		ACT_RELEASE
	} action_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TAKEN,
		ST_BAD_ID,
		ST_NOT_HELD,
		ST_LIMIT
	} status_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [15:0] count_limit;
		logic        seed_load;
		logic [15:0] seed;
	} cfg_t;

	// One step of the Galois LFSR x^16+x^14+x^13+x^11+1
	function automatic logic [15:0] lfsr_step(input logic [15:0] l);
		return (l >> 1) ^ (l[0] ? LFSR_TAPS : 16'h0000);
	endfunction

	// A zero seed would lock the LFSR; load it as one
	function automatic logic [15:0] seed_fix(input logic [15:0] s);
		return (s == 16'h0000) ? 16'h0001 : s;
	endfunction

endpackage

@@ hw/rtl/bitmap_id_allocator_core.sv @@
// Bitmap identifier allocator: hands out 15-bit identifiers from a 1024 x 32 bitmap held in
// one single-port-read RAM, and checks, requests or releases given identifiers, reporting
// errors as status codes. After reset the block sweeps the bitmap to zero and takes no word
// until the sweep ends; configuration writes are taken throughout. One word is handled at a
// time: a bad identifier, an ignored release of -1 or an allocation refused at the count
// limit goes from accept straight to output; check, request and release pass through accept,
// RAM read, evaluate and write back, and output. Allocation probes bitmap words one at a time,
// each probe being one RAM read followed by a compare of the registered data; with occupancy
// at half a few probes are typical, and the worst case is 1024 random and 1024 linear probes.
// A finished result waits in the output register while the next word is taken. Writing
// probe_seed reloads the probe LFSR (zero loads as one) unless a probe steps it in that cycle.
module bitmap_id_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bia_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input words
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] ident
	input  logic [1:0]                  s_tuser,   // [1:0] action
	// result words
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata    // [0] granted, [15:1] ident_out,
	                                               // [18:16] status, [34:19] in_use, [39:35] 0
);

	import bia_pkg::*;

	cfg_t          cfg;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic          granted;
	logic [14:0]   ident_out;
	status_t       status;
	logic [15:0]   in_use;

	bia_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bia_ram #(
		.WIDTH (32),
		.DEPTH (WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bia_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.s_action  (action_t'(s_tuser)),
		.s_ident   (s_tdata),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_granted (granted),
		.m_ident   (ident_out),
		.m_status  (status),
		.m_in_use  (in_use),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Pack the result fields, lowest field first
	assign m_tdata = {5'b00000, in_use, status, ident_out, granted};

endmodule

@@ hw/rtl/bia_ram.sv @@
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/bia_cfg.sv @@
module bia_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bia_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bia_pkg::cfg_t               cfg
);

	import bia_pkg::*;

	logic [15:0] limit_q;
	logic [15:0] seed_q;
	logic        wr_en;
	reg_sel_t    sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign sel    = reg_sel_t'(paddr[2]);

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			seed_q  <= SEED_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_COUNT_LIMIT: limit_q <= pwdata[15:0];
				REG_PROBE_SEED:  seed_q  <= pwdata[15:0];
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (sel)
			REG_COUNT_LIMIT: prdata = {16'h0000, limit_q};
			REG_PROBE_SEED:  prdata = {16'h0000, seed_q};
		endcase
	end

	// A seed write reloads the probe LFSR, unless a probe steps the LFSR in that cycle
	assign cfg.count_limit = limit_q;
	assign cfg.seed        = pwdata[15:0];
	assign cfg.seed_load   = wr_en && (sel == REG_PROBE_SEED);

endmodule

@@ hw/rtl/bia_seq.sv @@
module bia_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bia_pkg::cfg_t            cfg,
	input  logic                     s_valid,
	output logic                     s_ready,
	input  bia_pkg::action_t         s_action,
	input  logic [15:0]              s_ident,
	output logic                     m_valid,
	input  logic                     m_ready,
	output logic                     m_granted,
	output logic [14:0]              m_ident,
	output bia_pkg::status_t         m_status,
	output logic [15:0]              m_in_use,
	output logic                     ram_we,
	output logic [bia_pkg::AW-1:0]   ram_waddr,
	output logic [31:0]              ram_wdata,
	output logic                     ram_re,
	output logic [bia_pkg::AW-1:0]   ram_raddr,
	input  logic [31:0]              ram_rdata
);

	import bia_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_PUSH
	} state_t;

	state_t      state_q;
	action_t     act_q;
	logic [AW-1:0] addr_q;
	logic [4:0]  bit_q;
	logic [15:0] lfsr_q;
	logic [15:0] lfsr_n;
	logic [15:0] count_q;
	logic [TW-1:0] tries_q;
	logic        linear_q;
	logic        res_granted_q;
	logic [14:0] res_ident_q;
	status_t     res_status_q;
	logic        m_valid_q;
	logic        out_granted_q;
	logic [14:0] out_ident_q;
	status_t     out_status_q;
	logic [15:0] out_in_use_q;

	logic        word_full;
	logic        bit_taken;
	logic        at_limit;
	logic [4:0]  zero_pos;
	logic        bad_ident;
	logic [AW-1:0] addr_wrap;

	// Lowest clear bit of a word; a full word gives bit 31
	function automatic logic [4:0] lowest_zero(input logic [31:0] w);
		logic [4:0] pos;
		pos = 5'd31;
		for (int i = 31; i >= 0; i--) begin
			if (!w[i]) pos = 5'(i);
		end
		return pos;
	endfunction

	assign word_full = (ram_rdata == FULL_WORD);
	assign bit_taken = ram_rdata[bit_q];
	assign at_limit  = (count_q >= cfg.count_limit);
	assign zero_pos  = lowest_zero(ram_rdata);
	assign bad_ident = s_ident[15] || ({1'b0, s_ident} >= IDENT_LIMIT);
	assign lfsr_n    = lfsr_step(lfsr_q);
	assign addr_wrap = (addr_q == AW'(USE_WORDS - 1)) ? '0 : addr_q + 1'b1;

	// Memory port: clearing sweep, probe reads and read-modify-write
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ram_rdata;
		ram_waddr = addr_q;
		ram_re    = (state_q == S_READ);
		ram_raddr = addr_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
		end else if (state_q == S_EVAL) begin
			unique case (act_q)
				ACT_ALLOC: begin
					ram_we    = !word_full;
					ram_wdata = ram_rdata | (32'd1 << zero_pos);
				end
				ACT_CHECK: ram_we = 1'b0;
				ACT_REQUEST: begin
					ram_we    = !bit_taken && !at_limit;
					ram_wdata = ram_rdata | (32'd1 << bit_q);
				end
				ACT_RELEASE: begin
					ram_we    = bit_taken;
					ram_wdata = ram_rdata & ~(32'd1 << bit_q);
				end
			endcase
		end
	end

	// Sequencer: state, probe LFSR, counter and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			act_q         <= ACT_ALLOC;
			addr_q        <= '0;
			bit_q         <= '0;
			lfsr_q        <= seed_fix(SEED_RESET);
			count_q       <= '0;
			tries_q       <= '0;
			linear_q      <= 1'b0;
			res_granted_q <= 1'b0;
			res_ident_q   <= '0;
			res_status_q  <= ST_OK;
			m_valid_q     <= 1'b0;
			out_granted_q <= 1'b0;
			out_ident_q   <= '0;
			out_status_q  <= ST_OK;
			out_in_use_q  <= '0;
		end else begin
			if (m_valid_q && m_ready && state_q != S_PUSH) begin
				m_valid_q <= 1'b0;
			end
			if (cfg.seed_load) begin
				lfsr_q <= seed_fix(cfg.seed);
			end
			unique case (state_q)
				// Sweep the bitmap to zero after reset
				S_CLEAR: begin
					if (addr_q == AW'(WORDS - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				// Take a word and decide what to read
				S_IDLE: begin
					if (s_valid) begin
						act_q         <= s_action;
						res_granted_q <= 1'b0;
						if (s_action == ACT_ALLOC) begin
							res_ident_q <= '0;
							if (at_limit) begin
								res_status_q <= ST_LIMIT;
								state_q      <= S_PUSH;
							end else begin
								res_status_q <= ST_OK;
								lfsr_q   <= lfsr_n;
								addr_q   <= AW'(lfsr_n % 16'(USE_WORDS));
								tries_q  <= TW'(1);
								linear_q <= 1'b0;
								state_q  <= S_READ;
							end
						end else if (s_action == ACT_RELEASE && s_ident == NO_IDENT) begin
							res_ident_q  <= '0;
							res_status_q <= ST_OK;
							state_q      <= S_PUSH;
						end else if (bad_ident) begin
							res_ident_q  <= '0;
							res_status_q <= ST_BAD_ID;
							state_q      <= S_PUSH;
						end else begin
							res_status_q <= ST_OK;
							addr_q      <= AW'(s_ident[UAW+4:5]);
							bit_q       <= s_ident[4:0];
							res_ident_q <= s_ident[14:0];
							state_q     <= S_READ;
						end
					end
				end
				// Read data arrives next cycle
				S_READ: state_q <= S_EVAL;
				// Evaluate the word just read
				S_EVAL: begin
					unique case (act_q)
						ACT_ALLOC: begin
							if (!word_full) begin
								count_q       <= count_q + 1'b1;
								res_granted_q <= 1'b1;
								res_ident_q   <= 15'({addr_q[UAW-1:0], zero_pos});
								state_q       <= S_PUSH;
							end else if (tries_q < TW'(USE_WORDS)) begin
								// keep probing, random or linear
								tries_q <= tries_q + 1'b1;
								state_q <= S_READ;
								if (linear_q) begin
									addr_q <= addr_wrap;
								end else begin
									lfsr_q <= lfsr_n;
									addr_q <= AW'(lfsr_n % 16'(USE_WORDS));
								end
							end else if (!linear_q) begin
								// random probes spent: walk on from the last word
								linear_q <= 1'b1;
								tries_q  <= TW'(1);
								addr_q   <= addr_wrap;
								state_q  <= S_READ;
							end else begin
								res_status_q <= ST_LIMIT;
								state_q      <= S_PUSH;
							end
						end
						ACT_CHECK: begin
							res_granted_q <= !bit_taken;
							res_status_q  <= bit_taken ? ST_TAKEN : ST_OK;
							state_q       <= S_PUSH;
						end
						ACT_REQUEST: begin
							if (bit_taken) begin
								res_status_q <= ST_TAKEN;
							end else if (at_limit) begin
								res_status_q <= ST_LIMIT;
							end else begin
								count_q       <= count_q + 1'b1;
								res_granted_q <= 1'b1;
							end
							state_q <= S_PUSH;
						end
						ACT_RELEASE: begin
							if (!bit_taken) begin
								res_status_q <= ST_NOT_HELD;
							end else begin
								if (count_q != 16'd0) begin
									count_q <= count_q - 1'b1;
								end
								res_granted_q <= 1'b1;
							end
							state_q <= S_PUSH;
						end
					endcase
				end
				// Hand the result to the output register once it is free
				S_PUSH: begin
					if (!m_valid_q || m_ready) begin
						m_valid_q     <= 1'b1;
						out_granted_q <= res_granted_q;
						out_ident_q   <= res_ident_q;
						out_status_q  <= res_status_q;
						out_in_use_q  <= count_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_ready   = (state_q == S_IDLE);
	assign m_valid   = m_valid_q;
	assign m_granted = out_granted_q;
	assign m_ident   = out_ident_q;
	assign m_status  = out_status_q;
	assign m_in_use  = out_in_use_q;

	// Bitmap is written only by the sweep or by evaluation
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_EVAL))
		else $error("bitmap written outside sweep or evaluation");

	// Count moves only when a word is evaluated
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EVAL) |=> (count_q == $past(count_q)))
		else $error("identifier count changed outside evaluation");

	// A granted result always carries ok status
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && res_granted_q) |-> (res_status_q == ST_OK))
		else $error("granted result with error status");

	// Probe count stays within one pass over the usable words
	a_tries_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && act_q == ACT_ALLOC)
		|-> (tries_q != '0 && tries_q <= TW'(USE_WORDS)))
		else $error("probe count out of range");

endmodule
